/* design/tebs_pkg.sv */
package tebs_pkg;

   localparam int TIME_W   = 48;
   localparam int START_W  = 47;
   localparam int LEN_W    = 13;
   localparam int KIND_W   = 5;
   localparam int TARGET_W = 32;
   localparam int ARG_W    = 64;

   localparam logic OP_SCHEDULE = 1'b0;
   localparam logic OP_FIRE     = 1'b1;

   typedef struct packed {
      logic [ARG_W-1:0]         argument;
      logic [TARGET_W-1:0]      target;
      logic [KIND_W-1:0]        kind;
      logic signed [TIME_W-1:0] ev_time;
   } entry_type;

   typedef struct packed {
      logic shift;
      logic load;
   } cell_ctl_type;

   typedef enum logic [2:0] {
      ST_FIRED    = 3'd0,
      ST_STORED   = 3'd1,
      ST_EVICTED  = 3'd2,
      ST_DROPPED  = 3'd3,
      ST_NONE_DUE = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCHED,
      S_EVSCAN,
      S_EVWRITE,
      S_RESULT,
      S_FIRE,
      S_FDONE
   } state_type;

endpackage

/* design/tebs_cell.sv */
module tebs_cell
   import tebs_pkg::*;
(
   input  logic         clock,
   input  cell_ctl_type ctl,
   input  entry_type    next_entry,
   input  entry_type    load_data,
   output entry_type    entry
);

   entry_type entry_ff;

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         entry_ff <= load_data;
      end else if (ctl.shift) begin
         entry_ff <= next_entry;
      end
   end

   assign entry = entry_ff;

endmodule

/* design/tebs_bank.sv */
module tebs_bank
   import tebs_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   shift_en,
   input  logic                                   load_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] load_idx,
   input  entry_type                              load_data,
   output entry_type                              head
);

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   entry_type cells [DEPTH];

   // ring: each cell takes its upper neighbor, the top cell takes the head
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      cell_ctl_type ctl;
      assign ctl.shift = shift_en;
      assign ctl.load  = load_en && (load_idx == IDX_W'(i));
      tebs_cell u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .next_entry (cells[(i + 1) % DEPTH]),
         .load_data  (load_data),
         .entry      (cells[i])
      );
   end

   assign head = cells[0];

endmodule

/* design/timed_event_bank_scheduler_top.sv */
// schedule item: goes through S_SCHED to S_RESULT when a free entry exists or it is dropped
// schedule into a full bank: one ring rotation in S_EVSCAN to find the victim, then S_EVWRITE
// fire item: one ring step per valid entry in S_FIRE, held while rsp stalls, then S_FDONE
// one item is worked at a time; a new item is taken in S_IDLE, after its last result is loaded
// reset (synchronous, active high) empties the bank and clears the handshake state
module timed_event_bank_scheduler_top
   import tebs_pkg::*;
#(
   parameter int BANK_DEPTH = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // frame_time, block_start, block_length, command_kind, command_target,
   // command_argument, zero pad
   input  logic [215:0] req_tdata,
   // opcode
   input  logic [0:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // fired_time, fired_kind, fired_target, fired_argument, zero pad
   output logic [151:0] rsp_tdata,
   // status
   output logic [2:0]   rsp_tuser,
   output logic         rsp_tlast
);

   localparam int IDX_W = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
   localparam int CNT_W = $clog2(BANK_DEPTH + 1);

   state_type              state_ff, state_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [CNT_W-1:0]       k_ff, k_in;
   logic [CNT_W-1:0]       n_ff, n_in;
   entry_type              cmd_ff, cmd_in;
   logic [START_W-1:0]     start_ff, start_in;
   logic [LEN_W-1:0]       len_ff, len_in;
   status_type             st_ff, st_in;
   logic signed [TIME_W-1:0] best_ff, best_in;
   logic [IDX_W-1:0]       pick_ff, pick_in;
   logic                   found_ff, found_in;
   logic                   pend_v_ff, pend_v_in;
   entry_type              pend_ff, pend_in;
   logic                   rsp_v_ff, rsp_v_in;
   entry_type              rsp_ff, rsp_in;
   status_type             rsp_st_ff, rsp_st_in;
   logic                   rsp_last_ff, rsp_last_in;

   logic                   shift_en, load_en;
   logic [IDX_W-1:0]       load_idx;
   entry_type              load_data, head;

   logic                   accept, out_free, due, clamp, cur;
   logic [TIME_W-1:0]      horizon;
   logic signed [TIME_W-1:0] clamp_t;
   entry_type              req_entry;
   logic                   bank_full, scan_end;

   tebs_bank #(.DEPTH(BANK_DEPTH)) u_bank (
      .clock     (clock),
      .shift_en  (shift_en),
      .load_en   (load_en),
      .load_idx  (load_idx),
      .load_data (load_data),
      .head      (head)
   );

   assign accept   = req_tvalid && req_tready;
   assign out_free = !rsp_v_ff || rsp_tready;

   assign req_entry.ev_time  = req_tdata[47:0];
   assign req_entry.kind     = req_tdata[112:108];
   assign req_entry.target   = req_tdata[144:113];
   assign req_entry.argument = req_tdata[208:145];

   // clamp past or negative times to the block start
   assign horizon = TIME_W'(start_ff) + TIME_W'(len_ff);
   assign clamp   = cmd_ff.ev_time <= $signed({1'b0, start_ff});
   assign clamp_t = clamp ? $signed({1'b0, start_ff}) : cmd_ff.ev_time;
   assign cur     = clamp || ($signed({cmd_ff.ev_time[TIME_W-1], cmd_ff.ev_time})
                              < $signed({1'b0, horizon}));

   assign due       = head.ev_time <= cmd_ff.ev_time;
   assign bank_full = count_ff == CNT_W'(BANK_DEPTH);
   assign scan_end  = k_ff == CNT_W'(BANK_DEPTH - 1);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = (req_tuser[0] == OP_FIRE) ? S_FIRE : S_SCHED;
            end
         end
         S_SCHED: begin
            state_in = (bank_full && cur) ? S_EVSCAN : S_RESULT;
         end
         S_EVSCAN: begin
            if (scan_end) begin
               state_in = S_EVWRITE;
            end
         end
         S_EVWRITE: state_in = S_RESULT;
         S_RESULT: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         S_FIRE: begin
            if (k_ff == n_ff) begin
               state_in = S_FDONE;
            end
         end
         S_FDONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      count_in    = count_ff;
      k_in        = k_ff;
      n_in        = n_ff;
      cmd_in      = cmd_ff;
      start_in    = start_ff;
      len_in      = len_ff;
      st_in       = st_ff;
      best_in     = best_ff;
      pick_in     = pick_ff;
      found_in    = found_ff;
      pend_v_in   = pend_v_ff;
      pend_in     = pend_ff;
      rsp_v_in    = rsp_v_ff && !rsp_tready;
      rsp_in      = rsp_ff;
      rsp_st_in   = rsp_st_ff;
      rsp_last_in = rsp_last_ff;
      shift_en    = 1'b0;
      load_en     = 1'b0;
      load_idx    = '0;
      load_data   = head;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd_in    = req_entry;
               start_in  = req_tdata[94:48];
               len_in    = req_tdata[107:95];
               k_in      = '0;
               n_in      = count_ff;
               pend_v_in = 1'b0;
            end
         end
         S_SCHED: begin
            cmd_in.ev_time = clamp_t;
            if (!bank_full) begin
               load_en           = 1'b1;
               load_idx          = count_ff[IDX_W-1:0];
               load_data         = cmd_ff;
               load_data.ev_time = clamp_t;
               count_in          = count_ff + 1'b1;
               st_in             = ST_STORED;
            end else if (cur) begin
               best_in  = clamp_t;
               found_in = 1'b0;
               k_in     = '0;
            end else begin
               st_in = ST_DROPPED;
            end
         end
         S_EVSCAN: begin
            // full rotation brings the bank back to its order
            shift_en = 1'b1;
            k_in     = k_ff + 1'b1;
            if (head.ev_time > best_ff) begin
               best_in  = head.ev_time;
               pick_in  = k_ff[IDX_W-1:0];
               found_in = 1'b1;
            end
         end
         S_EVWRITE: begin
            if (found_ff) begin
               load_en   = 1'b1;
               load_idx  = pick_ff;
               load_data = cmd_ff;
               st_in     = ST_EVICTED;
            end else begin
               st_in = ST_DROPPED;
            end
         end
         S_RESULT: begin
            if (out_free) begin
               rsp_v_in    = 1'b1;
               rsp_in      = '0;
               rsp_st_in   = st_ff;
               rsp_last_in = 1'b1;
            end
         end
         S_FIRE: begin
            // queue over the valid prefix: survivors go back in at the tail
            if (k_ff != n_ff) begin
               if (!due || !pend_v_ff || out_free) begin
                  shift_en = 1'b1;
                  k_in     = k_ff + 1'b1;
                  if (due) begin
                     count_in  = count_ff - 1'b1;
                     pend_in   = head;
                     pend_v_in = 1'b1;
                     if (pend_v_ff) begin
                        rsp_v_in    = 1'b1;
                        rsp_in      = pend_ff;
                        rsp_st_in   = ST_FIRED;
                        rsp_last_in = 1'b0;
                     end
                  end else begin
                     load_en  = 1'b1;
                     load_idx = IDX_W'(count_ff - 1'b1);
                  end
               end
            end
         end
         S_FDONE: begin
            if (out_free) begin
               rsp_v_in    = 1'b1;
               rsp_last_in = 1'b1;
               if (pend_v_ff) begin
                  rsp_in    = pend_ff;
                  rsp_st_in = ST_FIRED;
                  pend_v_in = 1'b0;
               end else begin
                  rsp_in    = '0;
                  rsp_st_in = ST_NONE_DUE;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         count_ff  <= '0;
         pend_v_ff <= 1'b0;
         rsp_v_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         pend_v_ff <= pend_v_in;
         rsp_v_ff  <= rsp_v_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff        <= k_in;
      n_ff        <= n_in;
      cmd_ff      <= cmd_in;
      start_ff    <= start_in;
      len_ff      <= len_in;
      st_ff       <= st_in;
      best_ff     <= best_in;
      pick_ff     <= pick_in;
      found_ff    <= found_in;
      pend_ff     <= pend_in;
      rsp_ff      <= rsp_in;
      rsp_st_ff   <= rsp_st_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign req_tready = state_ff == S_IDLE;
   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata  = {3'b000, rsp_ff.argument, rsp_ff.target, rsp_ff.kind, rsp_ff.ev_time};
   assign rsp_tuser  = rsp_st_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule
